// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked out of reset
`define RBPE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rbpe assertion failed");

// property checked on every edge, reset included
`define RBPE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("rbpe assertion failed");

`endif

// File: src/rbpe_pkg.sv
// ----------------------------------------------------------------------------
// rbpe_pkg
// types, constants and fixed-point helpers of the rational b-spline evaluator
// ----------------------------------------------------------------------------
package rbpe_pkg;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    CMD_LOAD_POINT  = 2'd0,
    CMD_LOAD_WEIGHT = 2'd1,
    CMD_LOAD_KNOT   = 2'd2,
    CMD_EVALUATE    = 2'd3
  } cmd_t;

  localparam logic REG_CURVE_ORDER = 1'b0;
  localparam logic REG_POINT_COUNT = 1'b1;

  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;

  typedef enum logic [24:0] {
    S_IDLE = 25'd1 << 0,
    S_O1_A = 25'd1 << 1,
    S_O1_B = 25'd1 << 2,
    S_O1_C = 25'd1 << 3,
    S_K0   = 25'd1 << 4,
    S_K1   = 25'd1 << 5,
    S_K2   = 25'd1 << 6,
    S_K3   = 25'd1 << 7,
    S_K4   = 25'd1 << 8,
    S_DA   = 25'd1 << 9,
    S_WA   = 25'd1 << 10,
    S_DB   = 25'd1 << 11,
    S_WB   = 25'd1 << 12,
    S_M1   = 25'd1 << 13,
    S_M2   = 25'd1 << 14,
    S_M3   = 25'd1 << 15,
    S_SRD  = 25'd1 << 16,
    S_SW   = 25'd1 << 17,
    S_SX   = 25'd1 << 18,
    S_SY   = 25'd1 << 19,
    S_SN   = 25'd1 << 20,
    S_DX   = 25'd1 << 21,
    S_WX   = 25'd1 << 22,
    S_DY   = 25'd1 << 23,
    S_WY   = 25'd1 << 24
  } state_t;

  // signed value divided by 2^16, rounded toward zero
  function automatic logic signed [63:0] trunc_q16(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + (v[63] ? 64'sd65535 : 64'sd0);
    return b >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp_lim(input logic signed [63:0] v);
    if (v > 64'sd1073741824) return 32'sd1073741824;
    if (v < -64'sd1073741824) return -32'sd1073741824;
    return v[31:0];
  endfunction

  function automatic logic [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

endpackage

// File: src/rbpe_ram.sv
// ----------------------------------------------------------------------------
// rbpe_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rbpe_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/rational_bspline_point_evaluator_top.sv
// ----------------------------------------------------------------------------
// rational_bspline_point_evaluator_top
// rational b-spline curve point evaluation by the cox-de boor recursion
// ----------------------------------------------------------------------------
// in_* stream: in_tuser carries the command. load commands write a control
// point, weight or knot into its ram in the accept cycle and give no result.
// an evaluate item takes u from the value field and gives one result item on
// the out_* stream: point x/y and a zero weight sum flag in out_tuser.
// cfg_* writes curve_order (index 0) and point_count (index 1). the shared
// restoring divider and the single knot ram read port set the pace of an
// evaluate, and a multiplier feeds the sums. in_tready is low from an
// evaluate until its result is taken, so a stalled receiver holds the block.
// reset clears control state and sets curve_order 3, point_count 4; the rams
// keep their contents.
// ----------------------------------------------------------------------------
module rational_bspline_point_evaluator_top #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_ORDER  = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // index[6:0], coord_x[30:7], coord_y[54:31], value[71:55]
  input  logic [rbpe_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  logic [rbpe_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // point_x[23:0], point_y[47:24]
  output logic [rbpe_pkg::OUT_DATA_W-1:0]  out_tdata,
  // zero_weight_sum[0]
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [rbpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rbpe_pkg::*;

  localparam int KD  = MAX_POINTS + MAX_ORDER;
  localparam int KAW = $clog2(KD);
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int OW  = $clog2(MAX_ORDER + 2);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int TW  = $clog2(KD + 1);

  state_t state_r, state_nxt;

  logic [6:0]  in_idx;
  logic [23:0] in_cx, in_cy;
  logic [16:0] in_val, val_sat;
  cmd_t        in_cmd;
  logic        acc;

  logic [3:0]  order_raw_r;
  logic [6:0]  count_raw_r;
  logic        out_valid_r;
  logic [23:0] px_r, py_r;
  logic        zw_r;

  logic [16:0] t_r, ka_r, ki_r, ki1_r, kr1_r, kr_r;
  logic [OW-1:0] k_r, r_r, k_clamp;
  logic [NW-1:0] n_r, n_clamp;
  logic [TW-1:0] total_r, i_r;
  logic signed [31:0] nbi_r, nbi1_r, a_r, b_r, w_r;
  logic signed [63:0] left_r;
  logic signed [47:0] den_r;
  logic signed [63:0] sx_r, sy_r, p_r;

  logic          pt_we, wt_we, kn_we;
  logic [23:0]   x_rdata, y_rdata;
  logic [15:0]   w_rdata;
  logic [16:0]   kn_rdata;
  logic [31:0]   nb_rdata;
  logic [KAW-1:0] kaddr, naddr, nb_waddr;
  logic          nb_we;
  logic [31:0]   nb_wdata;

  logic signed [31:0] mul_a, mul_b, wc;
  logic signed [17:0] num_a, num_b, span_a, span_b;
  logic signed [63:0] p_q, right_c;

  logic               div_start, div_short;
  logic signed [63:0] div_num, div_den;
  logic [63:0]        dq_r, nmag, dmag;
  logic [47:0]        drem_r, ddiv_r;
  logic [6:0]         dcnt_r;
  logic               dneg_r;
  logic [48:0]        dshift;
  logic [49:0]        ddiff;
  logic signed [63:0] qs;

  assign in_idx = in_tdata[6:0];
  assign in_cx  = in_tdata[30:7];
  assign in_cy  = in_tdata[54:31];
  assign in_val = in_tdata[71:55];
  assign in_cmd = cmd_t'(in_tuser);
  assign val_sat = (in_val > ONE_Q16) ? ONE_Q16 : in_val;

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {py_r, px_r};
  assign out_tuser  = zw_r;

  assign pt_we = acc && (in_cmd == CMD_LOAD_POINT) && (int'(in_idx) < MAX_POINTS);
  assign wt_we = acc && (in_cmd == CMD_LOAD_WEIGHT) && (int'(in_idx) < MAX_POINTS);
  assign kn_we = acc && (in_cmd == CMD_LOAD_KNOT) && (int'(in_idx) < KD);

  always_comb begin
    if (order_raw_r == 4'd0) k_clamp = OW'(1);
    else if (int'(order_raw_r) > MAX_ORDER) k_clamp = OW'(MAX_ORDER);
    else k_clamp = OW'(order_raw_r);
    if (count_raw_r == 7'd0) n_clamp = NW'(1);
    else if (int'(count_raw_r) > MAX_POINTS) n_clamp = NW'(MAX_POINTS);
    else n_clamp = NW'(count_raw_r);
  end

  rbpe_ram #(.W(24), .D(MAX_POINTS)) u_xram (
    .clk, .we(pt_we), .waddr(PAW'(in_idx)), .wdata(in_cx),
    .raddr(i_r[PAW-1:0]), .rdata(x_rdata)
  );
  rbpe_ram #(.W(24), .D(MAX_POINTS)) u_yram (
    .clk, .we(pt_we), .waddr(PAW'(in_idx)), .wdata(in_cy),
    .raddr(i_r[PAW-1:0]), .rdata(y_rdata)
  );
  rbpe_ram #(.W(16), .D(MAX_POINTS)) u_wram (
    .clk, .we(wt_we), .waddr(PAW'(in_idx)),
    .wdata((in_val > 17'(WEIGHT_MAX)) ? WEIGHT_MAX : in_val[15:0]),
    .raddr(i_r[PAW-1:0]), .rdata(w_rdata)
  );
  rbpe_ram #(.W(17), .D(KD)) u_kram (
    .clk, .we(kn_we), .waddr(KAW'(in_idx)), .wdata(val_sat),
    .raddr(kaddr), .rdata(kn_rdata)
  );
  rbpe_ram #(.W(32), .D(KD)) u_nbram (
    .clk, .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
    .raddr(naddr), .rdata(nb_rdata)
  );

  assign num_a  = $signed({1'b0, t_r}) - $signed({1'b0, ki_r});
  assign span_a = $signed({1'b0, kr1_r}) - $signed({1'b0, ki_r});
  assign num_b  = $signed({1'b0, kr_r}) - $signed({1'b0, t_r});
  assign span_b = $signed({1'b0, kr_r}) - $signed({1'b0, ki1_r});
  assign p_q     = trunc_q16(p_r);
  assign wc      = p_q[31:0];
  assign right_c = p_q;
  assign qs      = dneg_r ? -$signed(dq_r) : $signed(dq_r);

  always_comb begin
    state_nxt = state_r;
    kaddr     = '0;
    naddr     = '0;
    nb_we     = 1'b0;
    nb_waddr  = i_r[KAW-1:0];
    nb_wdata  = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_short = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_cmd == CMD_EVALUATE) state_nxt = S_O1_A;
      end
      S_O1_A: state_nxt = S_O1_B;
      S_O1_B: begin
        kaddr     = KAW'(i_r + TW'(1));
        state_nxt = S_O1_C;
      end
      S_O1_C: begin
        nb_we    = 1'b1;
        nb_wdata = (t_r >= ka_r && t_r <= kn_rdata) ? 32'(ONE_Q16) : 32'd0;
        kaddr    = KAW'(i_r + TW'(2));
        if ((i_r + TW'(2)) == total_r) begin
          state_nxt = (k_r == OW'(1)) ? S_SRD : S_K0;
        end
      end
      S_K0: begin
        kaddr     = i_r[KAW-1:0];
        naddr     = i_r[KAW-1:0];
        state_nxt = S_K1;
      end
      S_K1: begin
        kaddr     = KAW'(i_r + TW'(1));
        naddr     = KAW'(i_r + TW'(1));
        state_nxt = S_K2;
      end
      S_K2: begin
        kaddr     = KAW'(i_r + TW'(r_r) - TW'(1));
        state_nxt = S_K3;
      end
      S_K3: begin
        kaddr     = KAW'(i_r + TW'(r_r));
        state_nxt = S_K4;
      end
      S_K4: state_nxt = S_DA;
      S_DA: begin
        div_num   = {{30{num_a[17]}}, num_a, 16'd0};
        div_den   = {{46{span_a[17]}}, span_a};
        div_short = 1'b1;
        if (span_a == 18'sd0) begin
          state_nxt = S_DB;
        end else begin
          div_start = 1'b1;
          state_nxt = S_WA;
        end
      end
      S_WA: if (dcnt_r == 7'd0) state_nxt = S_DB;
      S_DB: begin
        div_num   = {{30{num_b[17]}}, num_b, 16'd0};
        div_den   = {{46{span_b[17]}}, span_b};
        div_short = 1'b1;
        if (span_b == 18'sd0) begin
          state_nxt = S_M1;
        end else begin
          div_start = 1'b1;
          state_nxt = S_WB;
        end
      end
      S_WB: if (dcnt_r == 7'd0) state_nxt = S_M1;
      S_M1: begin
        mul_a     = a_r;
        mul_b     = nbi_r;
        state_nxt = S_M2;
      end
      S_M2: begin
        mul_a     = b_r;
        mul_b     = nbi1_r;
        state_nxt = S_M3;
      end
      S_M3: begin
        nb_we    = 1'b1;
        nb_wdata = clamp_lim(left_r + right_c);
        if ((i_r + TW'(r_r) + TW'(1)) == total_r) begin
          state_nxt = (r_r == k_r) ? S_SRD : S_K0;
        end else begin
          state_nxt = S_K0;
        end
      end
      S_SRD: begin
        naddr     = i_r[KAW-1:0];
        state_nxt = S_SW;
      end
      S_SW: begin
        naddr     = i_r[KAW-1:0];
        mul_a     = {16'd0, w_rdata};
        mul_b     = nb_rdata;
        state_nxt = S_SX;
      end
      S_SX: begin
        mul_a     = {{8{x_rdata[23]}}, x_rdata};
        mul_b     = wc;
        state_nxt = S_SY;
      end
      S_SY: begin
        mul_a     = {{8{y_rdata[23]}}, y_rdata};
        mul_b     = w_r;
        state_nxt = S_SN;
      end
      S_SN: state_nxt = ((i_r + TW'(1)) == TW'(n_r)) ? S_DX : S_SRD;
      S_DX: begin
        div_num = sx_r;
        div_den = {{16{den_r[47]}}, den_r};
        if (den_r == 48'sd0) begin
          state_nxt = S_DY;
        end else begin
          div_start = 1'b1;
          state_nxt = S_WX;
        end
      end
      S_WX: if (dcnt_r == 7'd0) state_nxt = S_DY;
      S_DY: begin
        div_num = sy_r;
        div_den = {{16{den_r[47]}}, den_r};
        if (den_r == 48'sd0) begin
          state_nxt = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_WY;
        end
      end
      S_WY: if (dcnt_r == 7'd0) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      order_raw_r <= 4'd3;
      count_raw_r <= 7'd4;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CURVE_ORDER: order_raw_r <= cfg_data[3:0];
          REG_POINT_COUNT: count_raw_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end else if ((state_r == S_WY && dcnt_r == 7'd0) ||
                   (state_r == S_DY && den_r == 48'sd0)) begin
        out_valid_r <= 1'b1;
      end
      if (div_start) dcnt_r <= div_short ? 7'd34 : 7'd64;
      else if (dcnt_r != 7'd0) dcnt_r <= dcnt_r - 7'd1;
    end
  end

  // shared restoring divider on magnitudes
  assign nmag   = div_num[63] ? 64'(-div_num) : 64'(div_num);
  assign dmag   = div_den[63] ? 64'(-div_den) : 64'(div_den);
  assign dshift = {drem_r, dq_r[63]};
  assign ddiff  = {1'b0, dshift} - {2'b00, ddiv_r};

  always_ff @(posedge clk) begin
    if (div_start) begin
      dneg_r <= div_num[63] ^ div_den[63];
      dq_r   <= div_short ? (nmag << 30) : nmag;
      drem_r <= '0;
      ddiv_r <= dmag[47:0];
    end else if (dcnt_r != 7'd0) begin
      if (!ddiff[49]) begin
        drem_r <= ddiff[47:0];
        dq_r   <= {dq_r[62:0], 1'b1};
      end else begin
        drem_r <= dshift[47:0];
        dq_r   <= {dq_r[62:0], 1'b0};
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        t_r     <= val_sat;
        k_r     <= k_clamp;
        n_r     <= n_clamp;
        total_r <= TW'(n_clamp) + TW'(k_clamp);
        i_r     <= '0;
        r_r     <= OW'(2);
        sx_r    <= '0;
        sy_r    <= '0;
        den_r   <= '0;
      end
      S_O1_B: ka_r <= kn_rdata;
      S_O1_C: begin
        ka_r <= kn_rdata;
        if ((i_r + TW'(2)) == total_r) i_r <= '0;
        else i_r <= i_r + TW'(1);
      end
      S_K1: begin
        ki_r  <= kn_rdata;
        nbi_r <= $signed(nb_rdata);
      end
      S_K2: begin
        ki1_r  <= kn_rdata;
        nbi1_r <= $signed(nb_rdata);
      end
      S_K3: kr1_r <= kn_rdata;
      S_K4: kr_r  <= kn_rdata;
      S_DA: if (span_a == 18'sd0) a_r <= 32'(num_a);
      S_WA: if (dcnt_r == 7'd0) a_r <= clamp_lim(qs);
      S_DB: if (span_b == 18'sd0) b_r <= 32'(num_b);
      S_WB: if (dcnt_r == 7'd0) b_r <= clamp_lim(qs);
      S_M2: left_r <= p_q;
      S_M3: begin
        if ((i_r + TW'(r_r) + TW'(1)) == total_r) begin
          i_r <= '0;
          r_r <= r_r + OW'(1);
        end else begin
          i_r <= i_r + TW'(1);
        end
      end
      S_SX: begin
        w_r   <= wc;
        den_r <= den_r + 48'(wc);
      end
      S_SY: sx_r <= sx_r + p_r;
      S_SN: begin
        sy_r <= sy_r + p_r;
        i_r  <= i_r + TW'(1);
      end
      S_DX: begin
        zw_r <= (den_r == 48'sd0);
        if (den_r == 48'sd0) px_r <= sat24(trunc_q16(sx_r));
      end
      S_WX: if (dcnt_r == 7'd0) px_r <= sat24(qs);
      S_DY: if (den_r == 48'sd0) py_r <= sat24(trunc_q16(sy_r));
      S_WY: if (dcnt_r == 7'd0) py_r <= sat24(qs);
      default: ;
    endcase
  end

endmodule

// File: src/rbpe_checker.sv
// ----------------------------------------------------------------------------
// rbpe_checker
// port-level checks of the rational b-spline evaluator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbpe_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [rbpe_pkg::IN_USER_W-1:0] in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready
);
  import rbpe_pkg::*;

  // result held until taken
  `RBPE_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  // evaluate makes the block busy
  `RBPE_ASSERT(a_eval_busy, clk, rst_n, in_tvalid && in_tready && in_tuser == CMD_EVALUATE |=> !in_tready)
  // no item taken while a result waits
  `RBPE_ASSERT(a_no_accept_pending, clk, rst_n, out_tvalid |-> !in_tready)
  // reset empties the output
  `RBPE_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_tvalid)

endmodule

bind rational_bspline_point_evaluator_top rbpe_checker u_rbpe_checker (.*);

// File: test/tb_rational_bspline_point_evaluator_top.sv
// ----------------------------------------------------------------------------
// tb_rational_bspline_point_evaluator_top
// self-checking bench for the rational b-spline point evaluator
// ----------------------------------------------------------------------------
// fills every point, weight and knot slot, then runs a short directed part
// (extreme fields, saturating loads, ignored slots, zero weight sum, order
// one, clamped registers) and random phases. each phase writes both
// registers, loads a knot vector, weights and points with some noise loads,
// and evaluates the curve at several u values. a scoreboard class keeps its
// own copy of the stores, predicts every curve point and checks each result
// item in order. both sides idle at random, and the receiver once holds off
// long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_rational_bspline_point_evaluator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbpe_pkg::*;

  localparam int NPTS = 64;
  localparam int NORD = 8;
  localparam int NKNOT = NPTS + NORD;
  localparam longint LIM = 64'sd1 << 30;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic        zw;
  } curve_point_t;

  class spline_scoreboard;
    longint px[NPTS], py[NPTS], wt[NPTS], kn[NKNOT];
    int unsigned order_reg = 3, count_reg = 4;
    curve_point_t points_due[$];
    int errors = 0;
    int results = 0;

    function longint lim30(longint v);
      if (v > LIM) return LIM;
      if (v < -LIM) return -LIM;
      return v;
    endfunction

    function logic [23:0] clip24(longint v);
      if (v > 8388607) return 24'h7FFFFF;
      if (v < -8388608) return 24'h800000;
      return v[23:0];
    endfunction

    function longint span_frac(longint num, longint span);
      if (span == 0) return lim30(num);
      return lim30((num * 65536) / span);
    endfunction

    function curve_point_t curve_at(longint t);
      longint nb[NKNOT];
      longint a, b, w, sx, sy, den;
      int k, n, total;
      curve_point_t p;
      k = order_reg; n = count_reg;
      if (k < 1) k = 1;
      if (k > NORD) k = NORD;
      if (n < 1) n = 1;
      if (n > NPTS) n = NPTS;
      total = n + k;
      sx = 0; sy = 0; den = 0;
      for (int i = 0; i + 1 < total; i++)
        nb[i] = (t >= kn[i] && t <= kn[i+1]) ? 65536 : 0;
      for (int r = 2; r <= k; r++) begin
        for (int i = 0; i + r < total; i++) begin
          a = span_frac(t - kn[i], kn[i+r-1] - kn[i]);
          b = span_frac(kn[i+r] - t, kn[i+r] - kn[i+1]);
          nb[i] = lim30((a * nb[i]) / 65536 + (b * nb[i+1]) / 65536);
        end
      end
      for (int i = 0; i < n; i++) begin
        w = (wt[i] * nb[i]) / 65536;
        den += w;
        sx += px[i] * w;
        sy += py[i] * w;
      end
      if (den != 0) begin
        p.x = clip24(sx / den); p.y = clip24(sy / den); p.zw = 1'b0;
      end else begin
        p.x = clip24(sx / 65536); p.y = clip24(sy / 65536); p.zw = 1'b1;
      end
      return p;
    endfunction

    function void note_item(cmd_t c, logic [6:0] idx, logic signed [23:0] x,
                            logic signed [23:0] y, logic [16:0] v);
      case (c)
        CMD_LOAD_POINT: begin
          if (idx < NPTS) begin px[idx] = x; py[idx] = y; end
        end
        CMD_LOAD_WEIGHT: begin
          if (idx < NPTS) wt[idx] = (v > 65535) ? 65535 : v;
        end
        CMD_LOAD_KNOT: begin
          if (idx < NKNOT) kn[idx] = (v > 65536) ? 65536 : v;
        end
        default: points_due.push_back(curve_at((v > 65536) ? 65536 : v));
      endcase
    endfunction

    function void set_reg(logic idx, logic [6:0] d);
      if (idx == REG_CURVE_ORDER) order_reg = d[3:0];
      else count_reg = d;
    endfunction

    function void check(logic [47:0] d, logic zw);
      curve_point_t e;
      results++;
      if (points_due.size() == 0) begin
        $error("result item with no evaluate pending");
        errors++;
        return;
      end
      e = points_due.pop_front();
      if (d[23:0] !== e.x) begin
        $error("point_x expected %0h actual %0h", e.x, d[23:0]); errors++;
      end
      if (d[47:24] !== e.y) begin
        $error("point_y expected %0h actual %0h", e.y, d[47:24]); errors++;
      end
      if (zw !== e.zw) begin
        $error("zero_weight_sum expected %0b actual %0b", e.zw, zw); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [IN_USER_W-1:0] in_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spline_scoreboard sb = new();
  int items_sent = 0;
  int quiet_cycles = 0;
  bit send_idle = 1;
  int eff_n = 4, eff_k = 3;
  int knot_vals[$];

  rational_bspline_point_evaluator_top DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_item(cmd_t'(in_tuser), in_tdata[6:0], in_tdata[30:7],
                     in_tdata[54:31], in_tdata[71:55]);
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_rational_bspline_point_evaluator_top NOT OK");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    int gap;
    bit rx_idle;
    bit held;
    rx_idle = 1;
    held = 0;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sb.results == 15) begin
        held = 1;
        out_tready <= 0;
        repeat (3000) @(negedge clk);
      end
      if ($urandom_range(0, 29) == 0) rx_idle = !rx_idle;
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  task automatic send_item(cmd_t c, logic [6:0] idx, logic [23:0] x,
                           logic [23:0] y, logic [16:0] v);
    int gap;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= c;
    in_tdata <= {v, y, x, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    @(negedge clk);
    while (sb.points_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] d);
    int k, n;
    wait_drained();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    k = sb.order_reg; n = sb.count_reg;
    eff_k = (k < 1) ? 1 : (k > NORD) ? NORD : k;
    eff_n = (n < 1) ? 1 : (n > NPTS) ? NPTS : n;
  endtask

  task automatic load_knots(int count, bit clamped);
    int v;
    knot_vals.delete();
    for (int i = 0; i < count; i++) knot_vals.push_back($urandom_range(0, 65536));
    knot_vals.sort();
    if (clamped)
      for (int i = 0; i < eff_k && i < count; i++) begin
        knot_vals[i] = 0;
        knot_vals[count-1-i] = 65536;
      end
    for (int i = 0; i < count; i++) begin
      v = knot_vals[i];
      if (v == 65536 && $urandom_range(0, 3) == 0) v = $urandom_range(65536, 131071);
      send_item(CMD_LOAD_KNOT, i, 0, 0, v);
    end
  endtask

  task automatic evaluate_at(int u);
    send_item(CMD_EVALUATE, $urandom, $urandom, $urandom, u);
  endtask

  initial begin
    int n_phase, bigs;
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    cfg_valid = 0; cfg_index = 0; cfg_data = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // fill every slot once
    for (int i = 0; i < NPTS; i++) begin
      send_item(CMD_LOAD_POINT, i, $urandom, $urandom, $urandom);
      send_item(CMD_LOAD_WEIGHT, i, 0, 0, $urandom_range(1, 65535));
    end
    load_knots(NKNOT, 1);

    // directed part
    load_knots(7, 1);
    evaluate_at(0);
    evaluate_at(65536);
    evaluate_at(131071);
    evaluate_at(32768);
    send_item(CMD_LOAD_WEIGHT, 0, 0, 0, 17'h1FFFF);
    send_item(CMD_LOAD_POINT, 1, 24'h800000, 24'h7FFFFF, 0);
    send_item(CMD_LOAD_POINT, 2, 24'h7FFFFF, 24'h800000, 0);
    send_item(CMD_LOAD_KNOT, 127, 0, 0, 12345);
    send_item(CMD_LOAD_POINT, 100, 24'h123456, 24'h654321, 0);
    send_item(CMD_LOAD_WEIGHT, 64, 0, 0, 0);
    evaluate_at(40000);
    for (int i = 0; i < 4; i++) send_item(CMD_LOAD_WEIGHT, i, 0, 0, 0);
    evaluate_at(30000);
    for (int i = 0; i < 4; i++) send_item(CMD_LOAD_WEIGHT, i, 0, 0, 65535);
    write_reg(REG_CURVE_ORDER, 1);
    evaluate_at(knot_vals[3]);
    write_reg(REG_CURVE_ORDER, 0);
    write_reg(REG_POINT_COUNT, 0);
    evaluate_at(20000);
    write_reg(REG_CURVE_ORDER, 7'h7F);
    write_reg(REG_POINT_COUNT, 7'h7F);
    evaluate_at(50000);

    // random phases
    n_phase = 0;
    bigs = 0;
    while (items_sent < 900) begin
      n_phase++;
      send_idle = $urandom_range(0, 2) != 0;
      if (bigs < 1 && n_phase == 12) begin
        bigs++;
        write_reg(REG_CURVE_ORDER, NORD);
        write_reg(REG_POINT_COUNT, NPTS);
      end else if ($urandom_range(0, 9) == 0) begin
        write_reg(REG_CURVE_ORDER, $urandom_range(0, 127));
        write_reg(REG_POINT_COUNT, $urandom_range(0, 12));
      end else begin
        write_reg(REG_CURVE_ORDER, $urandom_range(1, 4));
        write_reg(REG_POINT_COUNT, $urandom_range(1, 8));
      end
      load_knots(eff_n + eff_k, $urandom_range(0, 1));
      for (int i = 0; i < eff_n; i++) begin
        send_item(CMD_LOAD_WEIGHT, i, 0, 0,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                              : $urandom_range(1, 65535));
        send_item(CMD_LOAD_POINT, i, $urandom, $urandom, $urandom);
      end
      for (int j = $urandom_range(0, 3); j > 0; j--)
        send_item(cmd_t'($urandom_range(0, 1)), $urandom_range(NPTS, 127),
                  $urandom, $urandom, $urandom);
      for (int j = (eff_n * eff_k > 100) ? 2 : $urandom_range(3, 8); j > 0; j--)
        case ($urandom_range(0, 9))
          0: evaluate_at($urandom_range(0, 131071));
          1: evaluate_at(knot_vals[$urandom_range(0, knot_vals.size() - 1)]);
          default: evaluate_at($urandom_range(0, 65536));
        endcase
    end

    wait_drained();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.points_due.size() == 0)
      $display("tb_rational_bspline_point_evaluator_top OK");
    else
      $display("tb_rational_bspline_point_evaluator_top NOT OK");
    $finish;
  end

endmodule
